/* src/lgc_pkg.sv */
// shared types and constants of the linear gradient color block
// depends on nothing; imported by every module of the block
`default_nettype none

package lgc_pkg;

	// apb register map, one 32-bit word per register
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_POINT_A_X   = 3'd0;
	localparam logic [2:0] REG_POINT_A_Y   = 3'd1;
	localparam logic [2:0] REG_POINT_B_X   = 3'd2;
	localparam logic [2:0] REG_POINT_B_Y   = 3'd3;
	localparam logic [2:0] REG_COLOR_A     = 3'd4;
	localparam logic [2:0] REG_COLOR_B     = 3'd5;
	localparam logic [2:0] REG_SOLID_COLOR = 3'd6;
	localparam logic [2:0] REG_GRADIENT_ON = 3'd7;

	// one divider cell per quotient bit, q = floor(num * 2^17 / den)
	localparam int NUM_CELLS = 17;
	// s1..s4, divider cells, weight stage, product stage, output register
	localparam int PIPE_DEPTH = 4 + NUM_CELLS + 3;

	// t = 1.0 in q1.16
	localparam logic [16:0] T_ONE = 17'h10000;

	// how the blend weight of a request is chosen
	typedef enum logic [1:0] {
		MODE_SOLID,
		MODE_ZERO,
		MODE_ONE,
		MODE_DIV
	} lgc_mode_t;

	// configuration register file contents
	typedef struct packed {
		logic signed [15:0] point_a_x;
		logic signed [15:0] point_a_y;
		logic signed [15:0] point_b_x;
		logic signed [15:0] point_b_y;
		logic [31:0]        color_a;
		logic [31:0]        color_b;
		logic [31:0]        solid_color;
		logic               gradient_on;
	} lgc_cfg_t;

	// data handed from one divider cell to the next
	typedef struct packed {
		logic        valid;
		lgc_mode_t   mode;
		logic [33:0] rem;
		logic [33:0] den;
		logic [16:0] quo;
	} lgc_cell_t;

endpackage

`default_nettype wire

/* src/lgc_cfg.sv */
// apb configuration registers of the linear gradient color block
// depends on lgc_pkg
`default_nettype none

module lgc_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [lgc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output lgc_pkg::lgc_cfg_t              cfg
);
	import lgc_pkg::*;

	lgc_cfg_t    cfg_q;
	logic [2:0]  idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_POINT_A_X:   cfg_q.point_a_x   <= pwdata[15:0];
				REG_POINT_A_Y:   cfg_q.point_a_y   <= pwdata[15:0];
				REG_POINT_B_X:   cfg_q.point_b_x   <= pwdata[15:0];
				REG_POINT_B_Y:   cfg_q.point_b_y   <= pwdata[15:0];
				REG_COLOR_A:     cfg_q.color_a     <= pwdata;
				REG_COLOR_B:     cfg_q.color_b     <= pwdata;
				REG_SOLID_COLOR: cfg_q.solid_color <= pwdata;
				REG_GRADIENT_ON: cfg_q.gradient_on <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_POINT_A_X:   prdata = {16'b0, cfg_q.point_a_x};
			REG_POINT_A_Y:   prdata = {16'b0, cfg_q.point_a_y};
			REG_POINT_B_X:   prdata = {16'b0, cfg_q.point_b_x};
			REG_POINT_B_Y:   prdata = {16'b0, cfg_q.point_b_y};
			REG_COLOR_A:     prdata = cfg_q.color_a;
			REG_COLOR_B:     prdata = cfg_q.color_b;
			REG_SOLID_COLOR: prdata = cfg_q.solid_color;
			REG_GRADIENT_ON: prdata = {31'b0, cfg_q.gradient_on};
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* src/lgc_proj.sv */
// projection front end: dot product, squared length and weight classification
// depends on lgc_pkg; feeds the first divider cell
`default_nettype none

module lgc_proj (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire lgc_pkg::lgc_cfg_t  cfg,
	output lgc_pkg::lgc_cell_t      cell_o
);
	import lgc_pkg::*;

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [16:0] da_s1, db_s1, dx_s1, dy_s1;
	logic signed [33:0] pxd_s2, pyd_s2, sqx_s2, sqy_s2;
	logic signed [34:0] num_s3;
	logic [33:0]        den_s3;
	logic               num_low, num_high;
	lgc_mode_t          mode;
	lgc_cell_t          cell_s4;

	// s1: offsets from endpoint a
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		da_s1 <= {pos_x[15], pos_x} - {cfg.point_a_x[15], cfg.point_a_x};
		db_s1 <= {pos_y[15], pos_y} - {cfg.point_a_y[15], cfg.point_a_y};
		dx_s1 <= {cfg.point_b_x[15], cfg.point_b_x} - {cfg.point_a_x[15], cfg.point_a_x};
		dy_s1 <= {cfg.point_b_y[15], cfg.point_b_y} - {cfg.point_a_y[15], cfg.point_a_y};
	end

	// s2: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pxd_s2 <= da_s1 * dx_s1;
		pyd_s2 <= db_s1 * dy_s1;
		sqx_s2 <= dx_s1 * dx_s1;
		sqy_s2 <= dy_s1 * dy_s1;
	end

	// s3: dot product and squared length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_s3 <= $signed({pxd_s2[33], pxd_s2}) + $signed({pyd_s2[33], pyd_s2});
		den_s3 <= sqx_s2[33:0] + sqy_s2[33:0];
	end

	// s4: pick the weight case, seed the divider remainder
	assign num_low  = num_s3[34] || (num_s3 == '0);
	assign num_high = !num_s3[34] && (num_s3[33:0] >= den_s3);

	always_comb begin
		if (!cfg.gradient_on) begin
			mode = MODE_SOLID;
		end else if (den_s3 == '0 || num_low) begin
			mode = MODE_ZERO;
		end else if (num_high) begin
			mode = MODE_ONE;
		end else begin
			mode = MODE_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s4 <= '0;
		end else begin
			cell_s4.valid <= valid_s3;
			cell_s4.mode  <= mode;
			cell_s4.rem   <= (mode == MODE_DIV) ? num_s3[33:0] : '0;
			cell_s4.den   <= den_s3;
			cell_s4.quo   <= '0;
		end
	end

	assign cell_o = cell_s4;

endmodule

`default_nettype wire

/* src/lgc_div_cell.sv */
// one restoring division cell: produces one quotient bit per request
// depends on lgc_pkg; chained by the top level
`default_nettype none

module lgc_div_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lgc_pkg::lgc_cell_t cell_i,
	output lgc_pkg::lgc_cell_t     cell_o
);
	import lgc_pkg::*;

	logic [34:0] rem2;
	logic [34:0] diff;
	logic        take;
	lgc_cell_t   cell_q;

	// shift remainder, trial subtract
	assign rem2 = {cell_i.rem, 1'b0};
	assign diff = rem2 - {1'b0, cell_i.den};
	assign take = rem2 >= {1'b0, cell_i.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q.valid <= cell_i.valid;
			cell_q.mode  <= cell_i.mode;
			cell_q.den   <= cell_i.den;
			cell_q.rem   <= take ? diff[33:0] : rem2[33:0];
			cell_q.quo   <= {cell_i.quo[15:0], take};
		end
	end

	assign cell_o = cell_q;

	// remainder stays below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		cell_q.valid && cell_q.mode == MODE_DIV |-> cell_q.rem < cell_q.den)
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

/* src/lgc_blend.sv */
// blend back end: rounds the quotient to t, weights the two colors per channel
// depends on lgc_pkg; takes the last divider cell
`default_nettype none

module lgc_blend (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lgc_pkg::lgc_cell_t cell_i,
	input  wire lgc_pkg::lgc_cfg_t  cfg,
	output logic                    done,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue,
	output logic [7:0]              alpha
);
	import lgc_pkg::*;

	logic        valid_b1, valid_b2, done_q;
	logic        solid_b1, solid_b2;
	logic [16:0] t_b1;
	logic [17:0] quo_inc;
	logic [16:0] t_next;
	logic [16:0] w_a;
	logic [24:0] sum_b2 [4];
	logic [24:0] sum_next [4];
	logic [24:0] rnd [4];
	logic [7:0]  chan_q [4];

	// b1: rounded weight, half up
	assign quo_inc = {1'b0, cell_i.quo} + 18'd1;

	always_comb begin
		unique case (cell_i.mode)
			MODE_ONE: t_next = T_ONE;
			MODE_DIV: t_next = quo_inc[17:1];
			default:  t_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
		end else begin
			valid_b1 <= cell_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		t_b1     <= t_next;
		solid_b1 <= (cell_i.mode == MODE_SOLID);
	end

	// b2: weighted sum per channel
	assign w_a = T_ONE - t_b1;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_next[k] = 25'(cfg.color_a[31-8*k -: 8]) * 25'(w_a)
				+ 25'(cfg.color_b[31-8*k -: 8]) * 25'(t_b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b2 <= 1'b0;
		end else begin
			valid_b2 <= valid_b1;
		end
	end

	always_ff @(posedge clk) begin
		solid_b2 <= solid_b1;
		for (int k = 0; k < 4; k++) begin
			sum_b2[k] <= sum_next[k];
		end
	end

	// output register: round to nearest or pass the solid color
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rnd[k] = sum_b2[k] + 25'h8000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_b2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			chan_q[k] <= solid_b2 ? cfg.solid_color[31-8*k -: 8] : rnd[k][23:16];
		end
	end

	assign done  = done_q;
	assign red   = chan_q[0];
	assign green = chan_q[1];
	assign blue  = chan_q[2];
	assign alpha = chan_q[3];

endmodule

`default_nettype wire

/* src/linear_gradient_color.sv */
// top level of the linear gradient color block
// depends on lgc_pkg, lgc_cfg, lgc_proj, lgc_div_cell, lgc_blend
`default_nettype none

// Linear gradient color. Each request (pos_x, pos_y) is projected onto the
// line from point A to point B, the projection t is clamped to [0,1] in Q1.16
// and the RGBA colors of A and B are blended with weights 1-t and t, rounded
// per channel; with gradient_on low the solid color is returned, and when A
// equals B color A is returned. A request is taken on every clock (busy is
// always low) and its color comes out marked by done for one cycle. The
// pipeline is the 17-cell divider chain, one quotient bit per cell, between
// four projection stages and three blend stages. The receiver cannot stall
// the block. The user must see that registers are written over APB only
// while no request is in flight; the block itself does not enforce it.

module linear_gradient_color (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic signed [15:0]         pos_x,
	input  wire logic signed [15:0]         pos_y,
	output logic                            done,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic [7:0]                      alpha,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lgc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import lgc_pkg::*;

	lgc_cfg_t  cfg;
	lgc_cell_t chain [NUM_CELLS+1];
	logic      accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// register file
	lgc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// projection front end
	lgc_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.cfg      (cfg),
		.cell_o   (chain[0])
	);

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		lgc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cell_i (chain[i]),
			.cell_o (chain[i+1])
		);
	end

	// weighting and output register
	lgc_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.cell_i (chain[NUM_CELLS]),
		.cfg    (cfg),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.alpha  (alpha)
	);

	// every accepted request comes out of the pipeline marked by done
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_DEPTH done)
		else $error("accepted request did not complete");

	// no result without a request
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("result without a request");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// testbench for the linear gradient color block: directed and random vertices,
// with configuration over apb and a self-checking model of the color blend
// depends on lgc_pkg and linear_gradient_color
`timescale 1ns / 100ps

module tb_top;
	import lgc_pkg::*;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} vertex_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic signed [15:0]       pos_x = '0;
	logic signed [15:0]       pos_y = '0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [31:0]              pwdata = '0;
	wire logic                busy;
	wire logic                done;
	wire logic [7:0]          red;
	wire logic [7:0]          green;
	wire logic [7:0]          blue;
	wire logic [7:0]          alpha;
	wire logic [31:0]         prdata;
	wire logic                pready;

	// vertices waiting to be sent, colors waiting to come back
	vertex_t vertex_q[$];
	rgba_t   rgba_due_q[$];
	vertex_t next_vertex;
	rgba_t   want_rgba;
	rgba_t   got_rgba;

	// shadow of the register file, matches the reset values
	lgc_cfg_t cfg_shadow = '0;

	int send_gap_pct = 0;
	int mismatch_cnt = 0;

	linear_gradient_color dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.done    (done),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.alpha   (alpha),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// projection of a vertex onto a-b, clamped t in q1.16, rounded channel blend
	function automatic rgba_t blend_color(logic signed [15:0] px, logic signed [15:0] py);
		longint ax, ay, dx, dy, num, den, t, ca, cb;
		logic [31:0] mix;
		if (!cfg_shadow.gradient_on)
			return rgba_t'(cfg_shadow.solid_color);
		ax = longint'($signed(cfg_shadow.point_a_x));
		ay = longint'($signed(cfg_shadow.point_a_y));
		dx = longint'($signed(cfg_shadow.point_b_x)) - ax;
		dy = longint'($signed(cfg_shadow.point_b_y)) - ay;
		den = dx * dx + dy * dy;
		// coincident endpoints give color a
		if (den == 0)
			return rgba_t'(cfg_shadow.color_a);
		num = (longint'(px) - ax) * dx + (longint'(py) - ay) * dy;
		if (num <= 0)
			t = 0;
		else if (num >= den)
			t = 65536;
		else
			t = (num * 131072 + den) / (2 * den);
		for (int k = 0; k < 4; k++) begin
			ca = longint'((cfg_shadow.color_a >> (24 - 8 * k)) & 32'hFF);
			cb = longint'((cfg_shadow.color_b >> (24 - 8 * k)) & 32'hFF);
			mix[31 - 8 * k -: 8] = 8'((ca * (65536 - t) + cb * t + 32768) >> 16);
		end
		return rgba_t'(mix);
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint rand_coord();
		return longint'($signed(16'($urandom)));
	endfunction

	function automatic longint pick_extreme();
		case ($urandom_range(0, 2))
			0: return -32768;
			1: return 32767;
			default: return 0;
		endcase
	endfunction

	function automatic logic [31:0] rand_color();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// driver: new request whenever none is pending on the port
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (start)
				rgba_due_q.push_back(blend_color(pos_x, pos_y));
			if (vertex_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
				next_vertex = vertex_q.pop_front();
				start <= 1'b1;
				pos_x <= next_vertex.x;
				pos_y <= next_vertex.y;
			end else begin
				start <= 1'b0;
				pos_x <= 16'($urandom);
				pos_y <= 16'($urandom);
			end
		end
	end

	// monitor: each done strobe against the oldest predicted color
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_rgba = {red, green, blue, alpha};
			if (rgba_due_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: color %h with no request pending", $time, got_rgba);
			end else begin
				want_rgba = rgba_due_q.pop_front();
				if (got_rgba.r !== want_rgba.r || got_rgba.g !== want_rgba.g ||
						got_rgba.b !== want_rgba.b || got_rgba.a !== want_rgba.a) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: color mismatch, expected rgba %h got %h",
							$time, want_rgba, got_rgba);
				end
			end
		end
	end

	// apb write: setup then access cycle, shadow follows
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_POINT_A_X:   cfg_shadow.point_a_x = value[15:0];
			REG_POINT_A_Y:   cfg_shadow.point_a_y = value[15:0];
			REG_POINT_B_X:   cfg_shadow.point_b_x = value[15:0];
			REG_POINT_B_Y:   cfg_shadow.point_b_y = value[15:0];
			REG_COLOR_A:     cfg_shadow.color_a = value;
			REG_COLOR_B:     cfg_shadow.color_b = value;
			REG_SOLID_COLOR: cfg_shadow.solid_color = value;
			REG_GRADIENT_ON: cfg_shadow.gradient_on = value[0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input longint ax, input longint ay, input longint bx,
			input longint by, input logic [31:0] ca, input logic [31:0] cb,
			input logic [31:0] sc, input logic on);
		write_reg(REG_POINT_A_X, 32'(ax));
		write_reg(REG_POINT_A_Y, 32'(ay));
		write_reg(REG_POINT_B_X, 32'(bx));
		write_reg(REG_POINT_B_Y, 32'(by));
		write_reg(REG_COLOR_A, ca);
		write_reg(REG_COLOR_B, cb);
		write_reg(REG_SOLID_COLOR, sc);
		write_reg(REG_GRADIENT_ON, {31'd0, on});
	endtask

	task automatic add_vertex(input longint x, input longint y);
		vertex_t v;
		v.x = 16'(x);
		v.y = 16'(y);
		vertex_q.push_back(v);
	endtask

	// block until every queued request is sent and its color has come back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (vertex_q.size() != 0 || start || rgba_due_q.size() != 0);
	endtask

	// random endpoints and colors, then vertices mostly along the segment
	task automatic run_random_phase(input int n_items);
		longint ax, ay, bx, by, dx, dy, f, nzx, nzy;
		logic on;
		int sent, chunk, bursts;
		ax = rand_coord();
		ay = rand_coord();
		bx = rand_coord();
		by = rand_coord();
		case ($urandom_range(0, 5))
			1: begin
				bx = sat16(ax + longint'($urandom_range(0, 128)) - 64);
				by = sat16(ay + longint'($urandom_range(0, 128)) - 64);
			end
			2: by = ay;
			3: bx = ax;
			4: begin
				bx = ax;
				by = ay;
			end
			5: begin
				ax = pick_extreme();
				ay = pick_extreme();
				bx = pick_extreme();
				by = pick_extreme();
			end
			default: ;
		endcase
		on = ($urandom_range(0, 7) != 0);
		program_regs(ax, ay, bx, by, rand_color(), rand_color(), rand_color(), on);
		dx = bx - ax;
		dy = by - ay;
		sent = 0;
		bursts = 0;
		while (sent < n_items) begin
			chunk = $urandom_range(20, 60);
			for (int i = 0; i < chunk && sent < n_items; i++) begin
				if ($urandom_range(0, 9) < 2) begin
					add_vertex(rand_coord(), rand_coord());
				end else begin
					f = longint'($urandom_range(0, 384)) - 64;
					nzx = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 16)) - 8;
					nzy = ($urandom_range(0, 3) == 0) ? 0 : longint'($urandom_range(0, 16)) - 8;
					add_vertex(sat16(ax + dx * f / 256 + nzx), sat16(ay + dy * f / 256 + nzy));
				end
				sent++;
			end
			// sender holds off until the pipeline is empty now and then
			if (bursts == 0 || $urandom_range(0, 3) == 0)
				wait_idle();
			bursts++;
		end
		wait_idle();
	endtask

	// stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: gradient off, solid black
		add_vertex(0, 0);
		add_vertex(-32768, 32767);
		wait_idle();

		// horizontal segment: before a, at a, a small step, midpoint, at b, beyond b
		program_regs(0, 0, 256, 0, 32'hFF00_8001, 32'h00FF_7FFE, 32'h1234_5678, 1'b1);
		add_vertex(-16, 5);
		add_vertex(0, 0);
		add_vertex(1, 0);
		add_vertex(128, 0);
		add_vertex(256, -3);
		add_vertex(400, 0);
		wait_idle();

		// vertical segment
		program_regs(0, -128, 0, 128, 32'h00FF_7FFE, 32'hFF00_8001, 32'h0, 1'b1);
		add_vertex(7, -128);
		add_vertex(0, 0);
		add_vertex(-32768, 32767);
		add_vertex(32767, -32768);
		wait_idle();

		// full range diagonal, black to white
		program_regs(-32768, -32768, 32767, 32767, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1);
		add_vertex(-32768, 32767);
		add_vertex(32767, 32767);
		add_vertex(0, 0);
		add_vertex(32767, -32768);
		add_vertex(-32768, -32768);
		wait_idle();

		// coincident endpoints fall back to color a
		program_regs(4660, -5, 4660, -5, 32'hA5C3_3C5A, 32'h0102_0304, 32'h0, 1'b1);
		add_vertex(0, 0);
		add_vertex(32767, -32768);
		wait_idle();

		// gradient off ignores the endpoints
		program_regs(-32768, -32768, 32767, 32767, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_vertex(0, 0);
		add_vertex(100, -100);
		wait_idle();

		// random phases, rotating sender gaps
		for (int p = 0; p < 10; p++) begin
			case (p % 3)
				0: send_gap_pct = 0;
				1: send_gap_pct = 80;
				default: send_gap_pct = 26;
			endcase
			run_random_phase(80);
		end

		wait_idle();
		repeat (PIPE_DEPTH + 8) @(negedge clk);
		if (mismatch_cnt == 0 && rgba_due_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit
	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
src/lgc_pkg.sv
src/lgc_cfg.sv
src/lgc_proj.sv
src/lgc_div_cell.sv
src/lgc_blend.sv
src/linear_gradient_color.sv
sim/tb_top.sv
